/* sv/bdi_pkg.sv */
package bdi_pkg;

  localparam int CHUNK_W = 64;
  localparam int SIZE_W = 7;
  localparam int SIZE_SAT = 127;
  localparam int DEFAULT_MAX_LINE_BYTES = 64;

  // base/delta encodings in order of preference, sizes in bytes
  localparam int NUM_ENC = 6;
  localparam int ENC_BASE_BYTES [NUM_ENC] = '{8, 4, 8, 2, 4, 8};
  localparam int ENC_DELTA_BYTES [NUM_ENC] = '{1, 1, 2, 1, 2, 4};

  localparam int SIZE_ALL_ZERO = 1;
  localparam int SIZE_REPEATED = 8;

endpackage

/* sv/bdi_chunk_if.sv */
interface bdi_chunk_if
  import bdi_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CHUNK_W-1:0] chunk;
  logic               last_chunk;

  modport source (output valid, output chunk, output last_chunk, input ready);
  modport sink (input valid, input chunk, input last_chunk, output ready);
endinterface

/* sv/bdi_result_if.sv */
interface bdi_result_if
  import bdi_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] compressed_bytes;

  modport source (output valid, output compressed_bytes, input ready);
  modport sink (input valid, input compressed_bytes, output ready);
endinterface

/* sv/bdi_compressed_length_core.sv */
// path: a line's final chunk is held in the input register, and its size is then registered in
// the result register; a final chunk waits only while the previous size is unsent
// throughput: one chunk per cycle while no final chunk waits; the per-chunk checks sit
// between the input register and the line state, so nothing iterates
// reset: rst_n synchronous active low; clears the pipeline valids, the chunk
// count and the per-encoding state, payload registers are left as they are
module bdi_compressed_length_core
  import bdi_pkg::*;
#(
  parameter int MAX_LINE_BYTES = DEFAULT_MAX_LINE_BYTES
) (
  input  logic         clk,
  input  logic         rst_n,
  bdi_chunk_if.sink    in_ch,
  bdi_result_if.source out_ch
);

  localparam int MAX_CHUNKS = MAX_LINE_BYTES / 8;
  localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
  localparam int SUM_W = CNT_W + 4;

  // input register
  logic               s1_valid_r, s1_valid_nxt;
  logic [CHUNK_W-1:0] s1_chunk_r;
  logic               s1_last_r;

  // line state
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CHUNK_W-1:0] first_r;
  logic               any_nonzero_r, any_nonzero_nxt;
  logic               any_differs_r, any_differs_nxt;
  logic [NUM_ENC-1:0] enc_broken_r;
  logic [NUM_ENC-1:0] enc_broken_c;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic [SIZE_W-1:0] out_size_r, out_size_nxt;

  logic               ends_line;
  logic               s2_go;
  logic               line_done;
  logic [CNT_W-1:0]   count_inc;
  logic [CHUNK_W-1:0] first_eff;
  logic               nonzero_c;
  logic               differs_c;
  logic [SUM_W-1:0]   enc_size [NUM_ENC];

  assign ends_line = s1_last_r || (count_r == CNT_W'(MAX_CHUNKS - 1));
  assign s2_go     = s1_valid_r && (!ends_line || !out_valid_r || out_ch.ready);
  assign line_done = s2_go && ends_line;
  assign in_ch.ready = !s1_valid_r || s2_go;

  assign s1_valid_nxt = in_ch.ready ? in_ch.valid : s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (in_ch.valid && in_ch.ready) begin
      s1_chunk_r <= in_ch.chunk;
      s1_last_r  <= in_ch.last_chunk;
    end
  end

  assign count_inc = count_r + CNT_W'(1);
  assign first_eff = (count_r == '0) ? s1_chunk_r : first_r;
  assign nonzero_c = any_nonzero_r || (s1_chunk_r != '0);
  assign differs_c = any_differs_r || (s1_chunk_r != first_eff);

  // one base/delta encoding per block; elements of a chunk are taken low first
  for (genvar k = 0; k < NUM_ENC; k++) begin : g_enc
    localparam int BB = ENC_BASE_BYTES[k];
    localparam int DB = ENC_DELTA_BYTES[k];
    localparam int BW = BB * 8;
    localparam int DW = DB * 8;
    localparam int NE = 8 / BB;
    localparam int DIFF_W = (BW == 64) ? 64 : BW + 1;
    localparam int MUL = NE * DB;

    logic [BW-1:0] base_r, base_c;
    logic          base_vld_r, base_vld_c;
    logic          broken_c;

    always_comb begin
      logic [BW-1:0]     elem;
      logic [BW:0]       dfull;
      logic [DIFF_W-1:0] d;
      logic              fit;
      base_c     = base_r;
      base_vld_c = base_vld_r;
      broken_c   = enc_broken_r[k];
      for (int e = 0; e < NE; e++) begin
        elem  = s1_chunk_r[e*BW +: BW];
        fit   = (&elem[BW-1:DW-1]) || !(|elem[BW-1:DW-1]);
        dfull = '0;
        d     = '0;
        if (!broken_c && !fit) begin
          // first element that does not fit on its own becomes the base
          if (!base_vld_c) begin
            base_c     = elem;
            base_vld_c = 1'b1;
          end
          dfull = {elem[BW-1], elem} - {base_c[BW-1], base_c};
          d     = dfull[DIFF_W-1:0];
          if (!((&d[DIFF_W-1:DW-1]) || !(|d[DIFF_W-1:DW-1]))) begin
            broken_c = 1'b1;
          end
        end
      end
    end

    assign enc_broken_c[k] = broken_c;
    assign enc_size[k] = SUM_W'(BB) + SUM_W'(count_inc) * SUM_W'(MUL);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        base_vld_r      <= 1'b0;
        enc_broken_r[k] <= 1'b0;
      end else if (s2_go) begin
        base_vld_r      <= line_done ? 1'b0 : base_vld_c;
        enc_broken_r[k] <= line_done ? 1'b0 : broken_c;
      end
    end

    always_ff @(posedge clk) begin
      if (s2_go) begin
        base_r <= base_c;
      end
    end
  end

  always_comb begin
    count_nxt       = count_r;
    any_nonzero_nxt = any_nonzero_r;
    any_differs_nxt = any_differs_r;
    if (s2_go) begin
      if (line_done) begin
        count_nxt       = '0;
        any_nonzero_nxt = 1'b0;
        any_differs_nxt = 1'b0;
      end else begin
        count_nxt       = count_inc;
        any_nonzero_nxt = nonzero_c;
        any_differs_nxt = differs_c;
      end
    end
  end

  always_comb begin
    logic [SUM_W-1:0] size;
    logic             found;
    size  = SUM_W'(count_inc) << 3;
    found = 1'b0;
    priority if (!nonzero_c) begin
      size = SUM_W'(SIZE_ALL_ZERO);
    end else if (!differs_c) begin
      size = SUM_W'(SIZE_REPEATED);
    end else begin
      for (int k = 0; k < NUM_ENC; k++) begin
        if (!found && !enc_broken_c[k]) begin
          size  = enc_size[k];
          found = 1'b1;
        end
      end
    end
    if (size > SUM_W'(SIZE_SAT)) begin
      out_size_nxt = SIZE_W'(SIZE_SAT);
    end else begin
      out_size_nxt = size[SIZE_W-1:0];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (line_done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r       <= '0;
      any_nonzero_r <= 1'b0;
      any_differs_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      count_r       <= count_nxt;
      any_nonzero_r <= any_nonzero_nxt;
      any_differs_r <= any_differs_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    if (s2_go && (count_r == '0)) begin
      first_r <= s1_chunk_r;
    end
    if (line_done) begin
      out_size_r <= out_size_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.compressed_bytes = out_size_r;

  a_result_from_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(line_done))
    else $error("result appeared without a line end");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_CHUNKS - 1))
    else $error("chunk count ran past the line length");

  a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    line_done |=> (count_r == '0) && !any_nonzero_r && !any_differs_r &&
                  (enc_broken_r == '0))
    else $error("line state not cleared after line end");

  a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_size_r != '0))
    else $error("zero compressed size");

endmodule

/* verif/tb_bdi_compressed_length_core.sv */
module tb_bdi_compressed_length_core;
  timeunit 1ns;
  timeprecision 1ps;

  import bdi_pkg::*;

  localparam int MAX_BYTES = 64;
  localparam int MAX_CHUNKS = MAX_BYTES / 8;
  localparam int RANDOM_CHUNKS = 1550;
  localparam int DRAIN_CYCLES = 8;
  localparam int PREDICTED = -1;
  localparam int NUM_ROWS = 24;

  typedef struct packed {
    logic [CHUNK_W-1:0] chunk;
    logic               last;
    int                 size;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  bdi_chunk_if  in_ch ();
  bdi_result_if out_ch ();

  bdi_compressed_length_core #(
    .MAX_LINE_BYTES(MAX_BYTES)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #2 clk = ~clk;

  // line state of the size predictor
  int                 line_chunks;
  logic [CHUNK_W-1:0] line_first;
  bit                 line_nonzero;
  bit                 line_differs;
  logic [CHUNK_W-1:0] enc_base [NUM_ENC];
  bit                 enc_broken [NUM_ENC];

  logic [SIZE_W-1:0] expected_sizes [$];
  int                mismatches = 0;
  int                chunks_sent = 0;
  bit                calm_in = 1'b0;
  bit                calm_out = 1'b0;

  // first two chunks of the raw line break every encoding
  stim_row_t directed_rows [NUM_ROWS] = '{
    '{64'h0000_0000_0000_0000, 1'b1, SIZE_ALL_ZERO},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, SIZE_REPEATED},
    '{64'h8000_7FFF_4000_C000, 1'b0, PREDICTED},
    '{64'h0123_4567_89AB_CDEF, 1'b0, PREDICTED},
    '{64'hFEDC_BA98_7654_3210, 1'b0, PREDICTED},
    '{64'h5555_AAAA_5555_AAAA, 1'b0, PREDICTED},
    '{64'hAAAA_5555_AAAA_5555, 1'b0, PREDICTED},
    '{64'hFFFF_0000_FFFF_0000, 1'b0, PREDICTED},
    '{64'h0000_FFFF_0000_FFFF, 1'b0, PREDICTED},
    '{64'h7FFF_FFFF_FFFF_FFFF, 1'b0, MAX_BYTES},
    '{64'h8000_0000_0000_0000, 1'b0, PREDICTED},
    '{64'h7FFF_FFFF_FFFF_FFFF, 1'b1, PREDICTED},
    '{64'hFFFF_FFFF_FFFF_FF80, 1'b0, PREDICTED},
    '{64'h0000_0000_0000_007F, 1'b1, PREDICTED},
    '{64'h1000_0000_1000_0000, 1'b0, PREDICTED},
    '{64'h1000_0010_1000_0020, 1'b1, PREDICTED},
    '{64'h1000_0000_0000_0000, 1'b0, PREDICTED},
    '{64'h1000_0000_0000_1000, 1'b1, PREDICTED},
    '{64'h1000_1000_1000_1000, 1'b0, PREDICTED},
    '{64'h1001_1002_1003_1004, 1'b1, PREDICTED},
    '{64'h1000_0000_1000_0000, 1'b0, PREDICTED},
    '{64'h1000_0100_1000_0200, 1'b1, PREDICTED},
    '{64'h1000_0000_0000_0000, 1'b0, PREDICTED},
    '{64'h1000_0000_0100_0000, 1'b1, PREDICTED}
  };

  function automatic logic [CHUNK_W-1:0] widen(logic [CHUNK_W-1:0] v, int bits);
    int s;
    s = CHUNK_W - bits;
    return $signed(v << s) >>> s;
  endfunction

  function automatic bit fits_width(logic [CHUNK_W-1:0] v, int bits);
    logic [CHUNK_W-1:0] u;
    u = v + (64'd1 << (bits - 1));
    return (u >> bits) == 64'd0;
  endfunction

  function automatic logic [CHUNK_W-1:0] signed_rand(int bits);
    logic [CHUNK_W-1:0] d;
    d = {$urandom, $urandom};
    return widen(d, bits);
  endfunction

  task automatic clear_line();
    line_chunks = 0;
    line_first = '0;
    line_nonzero = 1'b0;
    line_differs = 1'b0;
    for (int k = 0; k < NUM_ENC; k++) begin
      enc_base[k] = '0;
      enc_broken[k] = 1'b0;
    end
  endtask

  task automatic size_step(input logic [CHUNK_W-1:0] c, input logic last,
                           output bit done, output int size);
    int bb;
    int dbits;
    int line_bytes;
    logic [CHUNK_W-1:0] x;
    done = 1'b0;
    size = 0;
    if (line_chunks == 0) line_first = c;
    if (c != '0) line_nonzero = 1'b1;
    if (c != line_first) line_differs = 1'b1;
    for (int k = 0; k < NUM_ENC; k++) begin
      bb = ENC_BASE_BYTES[k];
      dbits = ENC_DELTA_BYTES[k] * 8;
      for (int e = 0; e < 8 / bb; e++) begin
        if (!enc_broken[k]) begin
          x = widen(c >> (e * bb * 8), bb * 8);
          if (!fits_width(x, dbits)) begin
            // a chosen base never fits, so zero means none yet
            if (enc_base[k] == '0) enc_base[k] = x;
            if (!fits_width(x - enc_base[k], dbits)) enc_broken[k] = 1'b1;
          end
        end
      end
    end
    line_chunks++;
    if (!last && line_chunks < MAX_CHUNKS) return;
    done = 1'b1;
    line_bytes = line_chunks * 8;
    if (!line_nonzero) begin
      size = SIZE_ALL_ZERO;
    end else if (!line_differs) begin
      size = SIZE_REPEATED;
    end else begin
      size = line_bytes;
      for (int k = NUM_ENC - 1; k >= 0; k--) begin
        if (!enc_broken[k]) begin
          size = ENC_BASE_BYTES[k] + (line_bytes / ENC_BASE_BYTES[k]) * ENC_DELTA_BYTES[k];
        end
      end
    end
    if (size > SIZE_SAT) size = SIZE_SAT;
    clear_line();
  endtask

  // valid stays high after a transfer; callers lower it before any pause
  task automatic send_chunk(input logic [CHUNK_W-1:0] c, input logic last,
                            input int typed_size);
    int gap;
    bit done;
    int size;
    gap = calm_in ? 0 : $urandom_range(0, 3);
    if ($urandom_range(0, 63) == 0) calm_in = !calm_in;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.chunk      <= c;
    in_ch.last_chunk <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    chunks_sent++;
    size_step(c, last, done, size);
    if (done) begin
      expected_sizes.push_back(SIZE_W'((typed_size == PREDICTED) ? size : typed_size));
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_sizes.size() != 0) @(posedge clk);
  endtask

  function automatic logic [CHUNK_W-1:0] shaped_chunk(int bb, int db,
                                                       logic [CHUNK_W-1:0] base);
    logic [CHUNK_W-1:0] c;
    logic [CHUNK_W-1:0] elem;
    logic [CHUNK_W-1:0] mask;
    int r;
    c = '0;
    mask = (bb == 8) ? '1 : ((64'd1 << (bb * 8)) - 64'd1);
    for (int e = 0; e < 8 / bb; e++) begin
      r = $urandom_range(0, 15);
      if (r < 3) elem = signed_rand(db * 8);
      else if (r < 14) elem = base + signed_rand(db * 8);
      else if (r == 14) elem = base + signed_rand(db * 8 + 2);
      else elem = {$urandom, $urandom};
      c |= (elem & mask) << (e * bb * 8);
    end
    return c;
  endfunction

  task automatic random_line();
    int len;
    int mode;
    int k;
    bit self_end;
    logic [CHUNK_W-1:0] base;
    logic [CHUNK_W-1:0] rep;
    logic [CHUNK_W-1:0] c;
    len = ($urandom_range(0, 3) == 0) ? MAX_CHUNKS : $urandom_range(1, MAX_CHUNKS);
    self_end = (len == MAX_CHUNKS) && ($urandom_range(0, 1) == 1);
    mode = $urandom_range(0, 9);
    k = $urandom_range(0, NUM_ENC - 1);
    case ($urandom_range(0, 4))
      0: base = 64'h8000_0000_0000_0000;
      1: base = 64'h7FFF_FFFF_FFFF_FFFF;
      2: base = {$urandom, $urandom} >> $urandom_range(0, 63);
      default: base = {$urandom, $urandom};
    endcase
    rep = {$urandom, $urandom};
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: c = '0;
        1: c = ($urandom_range(0, 7) == 0) ? rep ^ (64'd1 << $urandom_range(0, 63)) : rep;
        2: c = {$urandom, $urandom};
        3: c = ($urandom_range(0, 3) == 0) ? signed_rand(8) : '0;
        default: c = shaped_chunk(ENC_BASE_BYTES[k], ENC_DELTA_BYTES[k], base);
      endcase
      send_chunk(c, (i == len - 1) && !self_end, PREDICTED);
    end
  endtask

  initial begin
    bit paused;
    paused = 1'b0;
    clear_line();
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.chunk      <= '0;
    in_ch.last_chunk <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < NUM_ROWS; i++) begin
      send_chunk(directed_rows[i].chunk, directed_rows[i].last, directed_rows[i].size);
    end
    wait_drained();
    while (chunks_sent < NUM_ROWS + RANDOM_CHUNKS) begin
      if (!paused && chunks_sent >= NUM_ROWS + RANDOM_CHUNKS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      random_line();
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("bdi_compressed_length_core: match");
    end else begin
      $display("bdi_compressed_length_core: mismatch");
    end
    $finish;
  end

  initial begin
    int stall;
    logic [SIZE_W-1:0] want;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = calm_out ? 0 : $urandom_range(0, 3);
      if ($urandom_range(0, 31) == 0) calm_out = !calm_out;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      if (expected_sizes.size() == 0) begin
        $display("%0t: compressed_bytes expected none actual %0d",
                 $time, out_ch.compressed_bytes);
        mismatches++;
      end else begin
        want = expected_sizes.pop_front();
        if (out_ch.compressed_bytes !== want) begin
          $display("%0t: compressed_bytes expected %0d actual %0d",
                   $time, want, out_ch.compressed_bytes);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("bdi_compressed_length_core: mismatch");
    $finish;
  end

endmodule
